/* design/mjp_pkg.sv */
// Shared constants, control word type and microcode table of the minimum-jerk pose profile.
`default_nettype none
package mjp_pkg;

    localparam int POS_W   = 32;             // pose word width, signed Q16.16
    localparam int PH_F    = 24;             // phase fraction bits
    localparam int STEP_W  = PH_F + 1;       // phase and phase step width
    localparam int CNT_W   = 16;             // sample counter width
    localparam int DIFF_W  = POS_W + 1;      // target minus start, signed
    localparam int DH_W    = DIFF_W - PH_F;  // high part of the difference
    localparam int POLY_W  = PH_F + 4;       // 10 - 15s + 6s^2 stays below 16.0
    localparam int MUL_A_W = POLY_W + 1;     // signed multiplier operand A
    localparam int MUL_B_W = STEP_W + 1;     // signed multiplier operand B
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int AX_N    = 3;              // x, y, theta
    localparam int AX_W    = 2;
    localparam int PC_W    = 4;

    localparam logic [STEP_W-1:0] ONE        = STEP_W'(1) << PH_F;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(16777);
    localparam logic [AX_W-1:0]   AX_LAST    = AX_W'(AX_N - 1);

    // Operand A selects.
    localparam logic [2:0] A_S    = 3'd0;
    localparam logic [2:0] A_S2   = 3'd1;
    localparam logic [2:0] A_POLY = 3'd2;
    localparam logic [2:0] A_DH   = 3'd3;
    localparam logic [2:0] A_DL   = 3'd4;

    // Operand B selects.
    localparam logic [1:0] B_S  = 2'd0;
    localparam logic [1:0] B_S3 = 2'd1;
    localparam logic [1:0] B_P  = 2'd2;

    // Write-back operations.
    localparam logic [2:0] WB_NONE = 3'd0;
    localparam logic [2:0] WB_S2   = 3'd1;
    localparam logic [2:0] WB_POLY = 3'd2;
    localparam logic [2:0] WB_S3   = 3'd3;
    localparam logic [2:0] WB_P    = 3'd4;
    localparam logic [2:0] WB_ACC  = 3'd5;
    localparam logic [2:0] WB_POSE = 3'd6;
    localparam logic [2:0] WB_EMIT = 3'd7;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_SQ    = 4'd0;
    localparam logic [PC_W-1:0] PC_S2    = 4'd1;
    localparam logic [PC_W-1:0] PC_CUBE  = 4'd2;
    localparam logic [PC_W-1:0] PC_S3    = 4'd3;
    localparam logic [PC_W-1:0] PC_BLEND = 4'd4;
    localparam logic [PC_W-1:0] PC_P     = 4'd5;
    localparam logic [PC_W-1:0] PC_DH    = 4'd6;
    localparam logic [PC_W-1:0] PC_DL    = 4'd7;
    localparam logic [PC_W-1:0] PC_POSE  = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;

    typedef struct packed {
        logic            mul_en;
        logic [2:0]      a_sel;
        logic [1:0]      b_sel;
        logic [2:0]      wb;
        logic            jump;     // jump while axes remain
        logic [PC_W-1:0] target;
    } t_ctrl;

    // The microprogram: one control word per step.
    function automatic t_ctrl ctrl_rom(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c = '{mul_en: 1'b0, a_sel: A_S, b_sel: B_S, wb: WB_NONE, jump: 1'b0, target: PC_SQ};
        case (pc)
            PC_SQ: begin
                c.mul_en = 1'b1; c.a_sel = A_S;    c.b_sel = B_S;
            end
            PC_S2: begin
                c.wb = WB_S2;
            end
            PC_CUBE: begin
                c.mul_en = 1'b1; c.a_sel = A_S2;   c.b_sel = B_S;  c.wb = WB_POLY;
            end
            PC_S3: begin
                c.wb = WB_S3;
            end
            PC_BLEND: begin
                c.mul_en = 1'b1; c.a_sel = A_POLY; c.b_sel = B_S3;
            end
            PC_P: begin
                c.wb = WB_P;
            end
            PC_DH: begin
                c.mul_en = 1'b1; c.a_sel = A_DH;   c.b_sel = B_P;
            end
            PC_DL: begin
                c.mul_en = 1'b1; c.a_sel = A_DL;   c.b_sel = B_P;  c.wb = WB_ACC;
            end
            PC_POSE: begin
                c.wb = WB_POSE;  c.jump = 1'b1;    c.target = PC_DH;
            end
            PC_EMIT: begin
                c.wb = WB_EMIT;
            end
            default: begin
                c.wb = WB_EMIT;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* design/mjp_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none
module mjp_mul (
    input  wire                               i_clk,
    input  wire                               i_en,
    input  wire signed [mjp_pkg::MUL_A_W-1:0] i_a,
    input  wire signed [mjp_pkg::MUL_B_W-1:0] i_b,
    output logic signed [mjp_pkg::MUL_P_W-1:0] o_p
);

    logic signed [mjp_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

/* design/min_jerk_pose_profile.sv */
// Top level of the minimum-jerk pose profile generator with its microcoded sequencer.
// A tick that finds a move active runs 16 microprogram steps on one shared
// multiplier (six for the blend, three per axis, one to emit); its result is presented
// by the final emit step, later while the previous result is still held.
// The input stays closed while the program runs, so a new tick is taken only after the
// emit step. Start transfers and idle ticks give no result.
// Reset (synchronous, active low) clears the move, the sequencer and the output valid,
// and loads the phase step with its default.
`default_nettype none
module min_jerk_pose_profile (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Configuration: phase step, unsigned Q1.24.
    input  wire          i_cfg_we,
    input  wire  [24:0]  i_cfg_wdata,
    // Input stream.
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: init_x, init_y, init_theta, target_x, target_y, target_theta (32 bits each)
    input  wire  [191:0] i_s_axis_tdata,
    // tuser: op (0 start a move, 1 time tick)
    input  wire          i_s_axis_tuser,
    // Output stream.
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // tdata: sample_index (16), phase_out (24), pose_x, pose_y, pose_theta (32 each)
    output logic [135:0] o_m_axis_tdata,
    // tlast: last sample of the move
    output logic         o_m_axis_tlast
);

    localparam int POS_W  = mjp_pkg::POS_W;
    localparam int PH_F   = mjp_pkg::PH_F;
    localparam int STEP_W = mjp_pkg::STEP_W;

    // Move state. The target is kept as its difference from the start, computed once at
    // the start transfer, so the tick program only needs one multiply input per step.
    logic [STEP_W-1:0]               r_phase_step;
    logic signed [POS_W-1:0]         r_start [mjp_pkg::AX_N];
    logic signed [mjp_pkg::DIFF_W-1:0] r_diff [mjp_pkg::AX_N];
    logic [STEP_W-1:0]               r_phase;
    logic [mjp_pkg::CNT_W-1:0]       r_count;
    logic                            r_active;

    // Sequencer.
    logic                            r_busy;
    logic [mjp_pkg::PC_W-1:0]        r_pc;
    logic [mjp_pkg::AX_W-1:0]        r_axis;
    mjp_pkg::t_ctrl                  w_ctrl;

    // Datapath registers.
    logic [PH_F-1:0]                 r_s2;
    logic [PH_F-1:0]                 r_s3;
    logic [mjp_pkg::POLY_W-1:0]      r_poly;
    logic [STEP_W-1:0]               r_p;
    logic [POS_W-1:0]                r_acc;
    logic [POS_W-1:0]                r_pose [mjp_pkg::AX_N];

    // Output register.
    logic                            r_out_valid;
    logic [135:0]                    r_out_data;
    logic                            r_out_last;

    logic signed [mjp_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [mjp_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [mjp_pkg::MUL_P_W-1:0] w_prod;

    logic                            w_in_xfer;
    logic                            w_start;
    logic                            w_tick;
    logic                            w_emit;
    logic [PH_F-1:0]                 w_s;
    logic [STEP_W:0]                 n_phase;
    logic                            w_last;
    logic [mjp_pkg::POLY_W:0]        w_poly;
    logic [mjp_pkg::POLY_W-1:0]      w_p_raw;
    logic signed [mjp_pkg::DIFF_W-1:0] w_diff;

    assign w_ctrl    = mjp_pkg::ctrl_rom(r_pc);
    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start   = w_in_xfer && !i_s_axis_tuser;
    // A tick only starts the program while a move is running; an idle tick is dropped.
    assign w_tick    = w_in_xfer && i_s_axis_tuser && r_active;
    assign w_s       = r_phase[PH_F-1:0];

    // The final step waits here until the output register is free or being emptied.
    assign w_emit = r_busy && (w_ctrl.wb == mjp_pkg::WB_EMIT)
                    && (!r_out_valid || i_m_axis_tready);

    assign n_phase = {1'b0, r_phase} + {1'b0, r_phase_step};
    assign w_last  = |n_phase[STEP_W:PH_F];

    // Blend polynomial 10 - 15 s + 6 s^2 in Q4.24; it stays positive below s = 1.0.
    assign w_poly = (mjp_pkg::POLY_W+1)'(10) * (mjp_pkg::POLY_W+1)'(mjp_pkg::ONE)
                    + ((mjp_pkg::POLY_W+1)'(r_s2) << 2) + ((mjp_pkg::POLY_W+1)'(r_s2) << 1)
                    - ((mjp_pkg::POLY_W+1)'(w_s) << 4) + (mjp_pkg::POLY_W+1)'(w_s);

    assign w_p_raw = w_prod[PH_F +: mjp_pkg::POLY_W];

    // Multiplier operand selection.
    assign w_diff = r_diff[r_axis];

    always_comb begin
        case (w_ctrl.a_sel)
            mjp_pkg::A_S:    w_mul_a = $signed({{(mjp_pkg::MUL_A_W-PH_F){1'b0}}, w_s});
            mjp_pkg::A_S2:   w_mul_a = $signed({{(mjp_pkg::MUL_A_W-PH_F){1'b0}}, r_s2});
            mjp_pkg::A_POLY: w_mul_a = $signed({1'b0, r_poly});
            // The high difference part is signed and is sign-extended.
            mjp_pkg::A_DH:   w_mul_a = mjp_pkg::MUL_A_W'($signed(
                                           w_diff[mjp_pkg::DIFF_W-1:PH_F]));
            mjp_pkg::A_DL:   w_mul_a = $signed({{(mjp_pkg::MUL_A_W-PH_F){1'b0}},
                                                w_diff[PH_F-1:0]});
            default:         w_mul_a = '0;
        endcase
        case (w_ctrl.b_sel)
            mjp_pkg::B_S:  w_mul_b = $signed({{(mjp_pkg::MUL_B_W-PH_F){1'b0}}, w_s});
            mjp_pkg::B_S3: w_mul_b = $signed({{(mjp_pkg::MUL_B_W-PH_F){1'b0}}, r_s3});
            mjp_pkg::B_P:  w_mul_b = $signed({1'b0, r_p});
            default:       w_mul_b = '0;
        endcase
    end

    mjp_mul u_mul (
        .i_clk (i_clk),
        .i_en  (r_busy && w_ctrl.mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= mjp_pkg::STEP_RESET;
            r_phase      <= '0;
            r_count      <= '0;
            r_active     <= 1'b0;
            r_busy       <= 1'b0;
            r_pc         <= mjp_pkg::PC_SQ;
            r_axis       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase_step <= i_cfg_wdata;
            end

            if (w_start) begin
                r_phase  <= '0;
                r_count  <= '0;
                r_active <= 1'b1;
            end else if (w_tick) begin
                r_busy <= 1'b1;
                r_pc   <= mjp_pkg::PC_SQ;
                r_axis <= '0;
            end else if (r_busy) begin
                if (w_ctrl.wb == mjp_pkg::WB_EMIT) begin
                    if (w_emit) begin
                        // Sample is out: advance the phase and retire the move at its end.
                        r_busy  <= 1'b0;
                        r_phase <= n_phase[STEP_W-1:0];
                        if (r_count != '1) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (w_last) begin
                            r_active <= 1'b0;
                        end
                    end
                end else if (w_ctrl.jump && (r_axis != mjp_pkg::AX_LAST)) begin
                    r_pc   <= w_ctrl.target;
                    r_axis <= r_axis + 1'b1;
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mjp_pkg::AX_N; k++) begin
                r_start[k] <= '0;
                r_diff[k]  <= '0;
            end
        end else if (w_start) begin
            for (int k = 0; k < mjp_pkg::AX_N; k++) begin
                r_start[k] <= $signed(i_s_axis_tdata[POS_W*k +: POS_W]);
                r_diff[k]  <= mjp_pkg::DIFF_W'($signed(i_s_axis_tdata[POS_W*(k+3) +: POS_W]))
                              - mjp_pkg::DIFF_W'($signed(i_s_axis_tdata[POS_W*k +: POS_W]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            case (w_ctrl.wb)
                mjp_pkg::WB_S2: begin
                    r_s2 <= w_prod[PH_F +: PH_F];
                end
                mjp_pkg::WB_POLY: begin
                    r_poly <= w_poly[mjp_pkg::POLY_W-1:0];
                end
                mjp_pkg::WB_S3: begin
                    r_s3 <= w_prod[PH_F +: PH_F];
                end
                mjp_pkg::WB_P: begin
                    // The truncated blend can overshoot 1.0 slightly; hold it there.
                    if (w_p_raw > mjp_pkg::POLY_W'(mjp_pkg::ONE)) begin
                        r_p <= mjp_pkg::ONE;
                    end else begin
                        r_p <= w_p_raw[STEP_W-1:0];
                    end
                end
                mjp_pkg::WB_ACC: begin
                    // start + high difference part times p; only the low word matters.
                    r_acc <= r_start[r_axis] + w_prod[POS_W-1:0];
                end
                mjp_pkg::WB_POSE: begin
                    // Add the low difference part times p, scaled back to Q16.16.
                    r_pose[r_axis] <= r_acc + {{(POS_W-PH_F){1'b0}}, w_prod[PH_F +: PH_F]};
                end
                mjp_pkg::WB_EMIT: begin
                    if (w_emit) begin
                        r_out_data <= {r_pose[2], r_pose[1], r_pose[0], w_s, r_count};
                        r_out_last <= w_last;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The input side is open whenever no tick program runs, even while a result waits.
    assign o_s_axis_tready = !r_busy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

/* design/mjp_checker.sv */
// Port-level assertions for the minimum-jerk pose profile, bound to its top level.
`default_nettype none
module mjp_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_s_axis_tvalid,
    input wire         o_s_axis_tready,
    input wire         i_s_axis_tuser,
    input wire         o_m_axis_tvalid,
    input wire         i_m_axis_tready,
    input wire [135:0] o_m_axis_tdata,
    input wire         o_m_axis_tlast
);

    // A result held back by the sink keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // Reset leaves no result pending and the input side open.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("reset did not clear the block");

    // A start transfer gives no result of its own.
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser && !o_m_axis_tvalid
            |=> !o_m_axis_tvalid)
        else $error("start transfer produced a result");

    // A new result only comes out of a running tick program, which closes the input.
    a_result_from_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result without a tick program");

endmodule

bind min_jerk_pose_profile mjp_checker u_mjp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire
